// File: hdl/hmcs_pkg.sv
package hmcs_pkg;

  // Grid geometry.
  localparam int MAX_SIDE = 256;
  localparam int ADDR_W   = $clog2(MAX_SIDE);
  localparam int CNT_W    = $clog2(MAX_SIDE + 1);
  localparam int CFG_W    = 9;
  localparam int MIN_SIDE = 2;

  // Datapath widths.
  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 11;
  localparam int MAG_W    = 10;
  localparam int NCNT_W   = 3;
  localparam int OUT_W    = 12;
  localparam int QUO_W    = 11;

  // Scaling: q = round(|S| * 64 / (5 * n)) = floor((128 * |S| + 5n) / (10n)).
  // The divide by 10n uses a reciprocal with a 2^24 scale, which is exact
  // for every numerator this block can form.
  localparam int NUM_SHIFT   = 7;
  localparam int NUM_W       = MAG_W + NUM_SHIFT;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 24;

  // Request kinds on the input channel.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  // Control from the frame counters to the line buffers.
  typedef struct packed {
    logic              step;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_new_addr;
    logic [ADDR_W-1:0] rd_old_addr;
  } win_ctrl_t;

  // Neighborhood taps of the current column, taken from the line buffers.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] left;
  } win_taps_t;

  // Reciprocal of 10n, scaled by 2^24 and rounded up.
  function automatic logic [RECIP_W-1:0] recip(input logic [NCNT_W-1:0] n);
    case (n)
      3'd3:    recip = 20'd559241;
      3'd4:    recip = 20'd419431;
      3'd5:    recip = 20'd335545;
      default: recip = 20'd335545;
    endcase
  endfunction

  // Half of the divisor, 5n, added before the divide for rounding.
  function automatic logic [NUM_W-1:0] half_den(input logic [NCNT_W-1:0] n);
    case (n)
      3'd3:    half_den = NUM_W'(15);
      3'd4:    half_den = NUM_W'(20);
      3'd5:    half_den = NUM_W'(25);
      default: half_den = NUM_W'(25);
    endcase
  endfunction

endpackage

// File: hdl/heightmap_cross_mean_smoother_unit.sv
// Five-point cross mean smoother for a square heightmap.
//
// Input channel (in_valid, in_stall, mode, sample): one request per cell in
// raster order; mode selects a height sample or a drain request. Output
// channel (out_valid, out_stall, smoothed_height, row_end, frame_end): the
// scaled neighborhood mean of one cell, with row and frame end flags.
// Configuration channel (cfg_valid, cfg_ready, side_length): sets the grid
// side and restarts the frame; cfg_ready is always high.
//
// Throughput is one request per cycle while in_stall is low, set by the
// single read and write port of each line buffer and a two-register
// datapath. A result passes through the datapath register and the output
// register. Results for row r are caused by the samples of row r+1; after
// the last row, one drain request per cell flushes it. Samples of the first
// row and ignored requests give no result. When the receiver stalls, the
// output register holds; the first register still takes a request while
// it is empty, then in_stall rises. Reset clears the counters and valid
// bits and sets the side to 256; the line buffers need no clearing.
module heightmap_cross_mean_smoother_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hmcs_pkg::CFG_W-1:0]            side_length,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic signed [hmcs_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [hmcs_pkg::OUT_W-1:0]     smoothed_height,
  output logic                                  row_end,
  output logic                                  frame_end
);
  import hmcs_pkg::*;

  // Frame state.
  logic [CNT_W-1:0]  side;
  logic [ADDR_W-1:0] col;
  logic [CNT_W-1:0]  row;
  logic              done;

  // Datapath register between the window and the scaler.
  logic              a_valid;
  logic              a_neg;
  logic [MAG_W-1:0]  a_mag;
  logic [NCNT_W-1:0] a_n;
  logic              a_row_end;
  logic              a_frame_end;

  logic              cfg_take;
  logic              take;
  logic              o_load;
  logic              a_load;
  logic              is_drain;
  logic              smp_ok;
  logic              drn_ok;
  logic              last_col;
  logic              produce;
  logic              has_down;
  logic              has_up;
  logic              has_left;
  logic              has_right;
  logic [CNT_W:0]    rd_new_sum;
  logic [CNT_W:0]    rd_new_wrap;
  logic signed [SUM_W-1:0] sum;
  logic [NCNT_W-1:0] n;
  logic [MAG_W-1:0]  mag;
  logic signed [OUT_W-1:0] scaled;
  win_ctrl_t         ctrl;
  win_taps_t         taps;

  // Handshakes: each register loads when it is empty or drains forward.
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign o_load    = !out_valid || !out_stall;
  assign a_load    = !a_valid || o_load;
  assign in_stall  = !a_load;
  assign take      = in_valid && !in_stall;

  // Request classification against the frame position.
  assign is_drain = (mode == MODE_DRAIN);
  assign smp_ok   = !is_drain && (row < side);
  assign drn_ok   = is_drain && (row == side) && !done;
  assign last_col = ((CNT_W'(col) + CNT_W'(1)) == side);
  assign produce  = drn_ok || (smp_ok && (row != '0));

  // Prefetch addresses, one column ahead of the window, wrapping at the side.
  assign rd_new_sum  = (CNT_W+1)'(col) + (CNT_W+1)'(2);
  assign rd_new_wrap = (rd_new_sum >= {1'b0, side}) ? (rd_new_sum - {1'b0, side}) : rd_new_sum;

  assign ctrl.step        = take && (smp_ok || drn_ok);
  assign ctrl.wr_en       = take && smp_ok;
  assign ctrl.wr_addr     = col;
  assign ctrl.rd_new_addr = rd_new_wrap[ADDR_W-1:0];
  assign ctrl.rd_old_addr = last_col ? '0 : (col + ADDR_W'(1));

  hmcs_linebuf u_linebuf (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (sample),
    .taps   (taps)
  );

  // Cross sum over the in-grid neighbors of the current cell.
  assign has_down  = !is_drain;
  assign has_up    = is_drain || (row > CNT_W'(1));
  assign has_left  = (col != '0);
  assign has_right = !last_col;

  always_comb begin
    sum = SUM_W'(taps.mid);
    if (has_down)  sum = sum + SUM_W'(sample);
    if (has_up)    sum = sum + SUM_W'(taps.up);
    if (has_left)  sum = sum + SUM_W'(taps.left);
    if (has_right) sum = sum + SUM_W'(taps.right);
  end

  assign n = NCNT_W'(1) + NCNT_W'(has_down) + NCNT_W'(has_up)
           + NCNT_W'(has_left) + NCNT_W'(has_right);
  assign mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

  // Side register and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      side <= CNT_W'(MAX_SIDE);
      col  <= '0;
      row  <= '0;
      done <= 1'b0;
    end else if (cfg_take) begin
      if (int'(side_length) < MIN_SIDE) begin
        side <= CNT_W'(MIN_SIDE);
      end else if (int'(side_length) > MAX_SIDE) begin
        side <= CNT_W'(MAX_SIDE);
      end else begin
        side <= CNT_W'(side_length);
      end
      col  <= '0;
      row  <= '0;
      done <= 1'b0;
    end else if (ctrl.step) begin
      col <= last_col ? '0 : (col + ADDR_W'(1));
      if (smp_ok && last_col) begin
        row <= row + CNT_W'(1);
      end
      if (drn_ok && last_col) begin
        done <= 1'b1;
      end
    end
  end

  // First datapath register: sign, magnitude, neighbor count and end flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= take && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load && take && produce) begin
      a_neg       <= sum[SUM_W-1];
      a_mag       <= mag;
      a_n         <= n;
      a_row_end   <= last_col;
      a_frame_end <= drn_ok && last_col;
    end
  end

  hmcs_scale u_scale (
    .neg   (a_neg),
    .mag   (a_mag),
    .n     (a_n),
    .value (scaled)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load && a_valid) begin
      smoothed_height <= scaled;
      row_end         <= a_row_end;
      frame_end       <= a_frame_end;
    end
  end

endmodule

// File: hdl/hmcs_linebuf.sv
module hmcs_linebuf (
  input  logic                               clk,
  input  hmcs_pkg::win_ctrl_t                ctrl,
  input  logic signed [hmcs_pkg::SAMPLE_W-1:0] sample,
  output hmcs_pkg::win_taps_t                taps
);
  import hmcs_pkg::*;

  // Line buffers: newer holds the previous row, older the row before it.
  logic [SAMPLE_W-1:0] newer_mem [MAX_SIDE];
  logic [SAMPLE_W-1:0] older_mem [MAX_SIDE];

  // Window registers for the current column; right and up are the
  // registered read data of the two buffers, fetched one column ahead.
  logic [SAMPLE_W-1:0] mid;
  logic [SAMPLE_W-1:0] right;
  logic [SAMPLE_W-1:0] up;
  logic [SAMPLE_W-1:0] left;

  // On each accepted sample or counted drain the window slides one column. The write to the newer
  // buffer is forwarded when the prefetch hits the same column, which only
  // happens on a two-cell side.
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      mid  <= right;
      left <= mid;
      up   <= older_mem[ctrl.rd_old_addr];
      if (ctrl.wr_en && (ctrl.rd_new_addr == ctrl.wr_addr)) begin
        right <= sample;
      end else begin
        right <= newer_mem[ctrl.rd_new_addr];
      end
      if (ctrl.wr_en) begin
        newer_mem[ctrl.wr_addr] <= sample;
        older_mem[ctrl.wr_addr] <= mid;
      end
    end
  end

  assign taps.mid   = mid;
  assign taps.right = right;
  assign taps.up    = up;
  assign taps.left  = left;

endmodule

// File: hdl/hmcs_scale.sv
module hmcs_scale (
  input  logic                                neg,
  input  logic [hmcs_pkg::MAG_W-1:0]          mag,
  input  logic [hmcs_pkg::NCNT_W-1:0]         n,
  output logic signed [hmcs_pkg::OUT_W-1:0]   value
);
  import hmcs_pkg::*;

  logic [NUM_W-1:0]         num;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [QUO_W-1:0]         quo;
  logic signed [OUT_W-1:0]  quo_ext;

  // Rounded numerator, then divide by 10n through its reciprocal.
  assign num  = {mag, {NUM_SHIFT{1'b0}}} + half_den(n);
  assign prod = num * recip(n);
  assign quo  = prod[RECIP_SHIFT +: QUO_W];

  // Apply the sign of the sum; rounding was done on the magnitude.
  assign quo_ext = {{(OUT_W-QUO_W){1'b0}}, quo};
  assign value   = neg ? -quo_ext : quo_ext;

endmodule

// File: hdl/hmcs_checker.sv
module hmcs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready,
  input logic [hmcs_pkg::CFG_W-1:0]            side_length,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  mode,
  input logic signed [hmcs_pkg::SAMPLE_W-1:0]  sample,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [hmcs_pkg::OUT_W-1:0]     smoothed_height,
  input logic                                  row_end,
  input logic                                  frame_end
);
  import hmcs_pkg::*;

  // A stalled result stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(smoothed_height) && $stable(row_end)
      && $stable(frame_end))
    else $error("stalled result changed");

  // The last cell of the grid is always the last cell of a row.
  a_frame_row : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !frame_end || row_end)
    else $error("frame end without row end");

  // A scaled mean of signed bytes stays within its range.
  a_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (smoothed_height >= -12'sd1639) && (smoothed_height <= 12'sd1626))
    else $error("smoothed height out of range");

  // Reset empties the output.
  a_reset : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind heightmap_cross_mean_smoother_unit hmcs_checker u_hmcs_checker (.*);

// File: tb/heightmap_cross_mean_smoother_unit_test.sv
`timescale 1ns / 1ps

module heightmap_cross_mean_smoother_unit_test;
  import hmcs_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int QUIET_LIMIT = 2000;
  localparam int FLUSH_WAIT  = 8;
  localparam int LARGE_SIDE  = 9'd511;
  localparam int SMALL_ITEMS = 200;

  localparam logic signed [SAMPLE_W-1:0] HEIGHT_MIN = 8'sh80;
  localparam logic signed [SAMPLE_W-1:0] HEIGHT_MAX = 8'sh7f;

  // One smoothed cell as it leaves the block.
  typedef struct packed {
    logic signed [OUT_W-1:0] height;
    logic                    last_col;
    logic                    last_cell;
  } cell_result_t;

  // Mirror of the smoother: line buffers, frame counters and the queue of
  // smoothed cells that the block still owes.
  class cross_mean_scoreboard;
    logic signed [SAMPLE_W-1:0] older_line [MAX_SIDE];
    logic signed [SAMPLE_W-1:0] newer_line [MAX_SIDE];
    int unsigned                col_pos;
    int unsigned                row_pos;
    int unsigned                drain_pos;
    logic [CFG_W-1:0]           side_reg;
    cell_result_t               owed_cells [$];
    int unsigned                errors;

    function new();
      side_reg  = CFG_W'(256);
      col_pos   = 0;
      row_pos   = 0;
      drain_pos = 0;
      errors    = 0;
      for (int i = 0; i < MAX_SIDE; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
    endfunction

    // A side write also starts a new frame.
    function void restart(logic [CFG_W-1:0] value);
      side_reg  = value;
      col_pos   = 0;
      row_pos   = 0;
      drain_pos = 0;
    endfunction

    function int unsigned grid_side();
      if (side_reg < MIN_SIDE) return MIN_SIDE;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return side_reg;
    endfunction

    // Mean times 0.05 in 1/256 units, rounded half away from zero.
    function logic signed [OUT_W-1:0] scaled_mean(int sum, int n);
      int mag;
      int den;
      int q;
      mag = ((sum < 0) ? -sum : sum) * 64;
      den = 5 * n;
      q   = (2 * mag + den) / (2 * den);
      if (sum < 0) q = -q;
      return q[OUT_W-1:0];
    endfunction

    function void note_request(logic kind, logic signed [SAMPLE_W-1:0] height);
      int unsigned  side;
      int unsigned  c;
      int           sum;
      int           n;
      cell_result_t owed;
      side = grid_side();
      if (kind == MODE_SAMPLE) begin
        // Samples past the last row are dropped.
        if (row_pos >= side) return;
        c = col_pos;
        if (row_pos > 0) begin
          sum = newer_line[c];
          sum += height;
          n = 2;
          if (row_pos > 1) begin
            sum += older_line[c];
            n++;
          end
          if (c > 0) begin
            sum += older_line[c-1];
            n++;
          end
          if (c + 1 < side) begin
            sum += newer_line[c+1];
            n++;
          end
          owed.height    = scaled_mean(sum, n);
          owed.last_col  = (c + 1 == side);
          owed.last_cell = 1'b0;
          owed_cells.push_back(owed);
        end
        older_line[c] = newer_line[c];
        newer_line[c] = height;
        c++;
        if (c >= side) begin
          c = 0;
          row_pos++;
        end
        col_pos = c;
      end else begin
        // Drains count only once the frame is complete and the last row
        // still has cells to flush.
        if (row_pos < side || drain_pos >= side) return;
        c   = drain_pos;
        sum = newer_line[c];
        sum += older_line[c];
        n = 2;
        if (c > 0) begin
          sum += older_line[c-1];
          n++;
        end
        if (c + 1 < side) begin
          sum += newer_line[c+1];
          n++;
        end
        owed.height    = scaled_mean(sum, n);
        owed.last_col  = (c + 1 == side);
        owed.last_cell = (c + 1 == side);
        owed_cells.push_back(owed);
        older_line[c] = newer_line[c];
        drain_pos     = c + 1;
      end
    endfunction

    function int unsigned pending();
      return owed_cells.size();
    endfunction

    function void check_result(logic signed [OUT_W-1:0] height, logic re, logic fe);
      cell_result_t want;
      if (owed_cells.size() == 0) begin
        $error("unexpected result: smoothed_height=%0d row_end=%0b frame_end=%0b",
               height, re, fe);
        errors++;
        return;
      end
      want = owed_cells.pop_front();
      if (height !== want.height) begin
        $error("smoothed_height: expected %0d, actual %0d", want.height, height);
        errors++;
      end
      if (re !== want.last_col) begin
        $error("row_end: expected %0b, actual %0b", want.last_col, re);
        errors++;
      end
      if (fe !== want.last_cell) begin
        $error("frame_end: expected %0b, actual %0b", want.last_cell, fe);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           side_length;
  logic                       in_valid;
  logic                       in_stall;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [OUT_W-1:0]    smoothed_height;
  logic                       row_end;
  logic                       frame_end;

  cross_mean_scoreboard sb;
  logic                 in_burst     = 1'b0;
  logic                 out_burst    = 1'b0;
  int unsigned          quiet_cycles = 0;
  int unsigned          small_count  = 0;

  heightmap_cross_mean_smoother_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .side_length     (side_length),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .smoothed_height (smoothed_height),
    .row_end         (row_end),
    .frame_end       (frame_end)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[heightmap_cross_mean_smoother_unit] ERROR");
      $finish;
    end
  end

  // Mostly random heights, with the extremes drawn often.
  function automatic logic signed [SAMPLE_W-1:0] pick_height();
    case ($urandom_range(0, 5))
      0:       return HEIGHT_MIN;
      1:       return HEIGHT_MAX;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one request after a random gap and hold it until accepted.
  // Entered and left at a falling edge.
  task automatic send_request(input logic kind, input logic signed [SAMPLE_W-1:0] height);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = kind;
    sample   = height;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(kind, height);
    @(negedge clk);
  endtask

  // Wait until every owed cell is out, then let the pipeline empty.
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_side(input logic [CFG_W-1:0] value);
    cfg_valid   = 1'b1;
    side_length = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.restart(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One frame with random content; a cut frame stops partway and leaves
  // the next side write to restart. Stray drains and samples are mixed in.
  task automatic run_frame(input int unsigned side, input logic cut);
    int unsigned cells;
    cells = side * side;
    if (cut) cells = $urandom_range(1, cells - 1);
    for (int unsigned i = 0; i < cells; i++) begin
      if ($urandom_range(0, 15) == 0) send_request(MODE_DRAIN, pick_height());
      send_request(MODE_SAMPLE, pick_height());
      small_count++;
    end
    if (cut) return;
    for (int unsigned i = 0; i < side; i++) begin
      if ($urandom_range(0, 15) == 0) send_request(MODE_SAMPLE, pick_height());
      send_request(MODE_DRAIN, pick_height());
      small_count++;
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) send_request(1'($urandom_range(0, 1)), pick_height());
    end
  endtask

  // Result side: random stall before each result, then take it.
  initial begin : result_sink
    int unsigned hold;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(smoothed_height, row_end, frame_end);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] side_value;
    int unsigned      side;
    sb          = new();
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    side_length = '0;
    in_valid    = 1'b0;
    mode        = MODE_SAMPLE;
    sample      = '0;
    out_stall   = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Side zero acts as the minimum 2x2 grid: an early drain, extreme
    // heights, a sample past the frame, the flush and one extra drain.
    settle();
    write_side('0);
    send_request(MODE_DRAIN, '0);
    send_request(MODE_SAMPLE, HEIGHT_MIN);
    send_request(MODE_SAMPLE, HEIGHT_MAX);
    send_request(MODE_SAMPLE, HEIGHT_MAX);
    send_request(MODE_SAMPLE, HEIGHT_MIN);
    send_request(MODE_SAMPLE, 8'sd55);
    repeat (3) send_request(MODE_DRAIN, HEIGHT_MAX);

    // A 3x3 grid of the top height reaches the full five-point cross.
    settle();
    write_side(CFG_W'(3));
    repeat (9) send_request(MODE_SAMPLE, HEIGHT_MAX);
    repeat (4) send_request(MODE_DRAIN, '0);

    // Widest grid, clamped from the largest side value: two rows and part of a
    // third, so the second row produces the first row's results in all columns.
    settle();
    write_side(CFG_W'(LARGE_SIDE));
    repeat (2 * MAX_SIDE + 16) send_request(MODE_SAMPLE, pick_height());

    // Many small frames, some of them cut short.
    while (small_count < SMALL_ITEMS) begin
      settle();
      if ($urandom_range(0, 9) == 0) side_value = CFG_W'($urandom_range(0, 1));
      else side_value = CFG_W'($urandom_range(2, 9));
      write_side(side_value);
      side = (side_value < MIN_SIDE) ? MIN_SIDE : side_value;
      run_frame(side, $urandom_range(0, 7) == 0);
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[heightmap_cross_mean_smoother_unit] OK");
    end else begin
      $display("[heightmap_cross_mean_smoother_unit] ERROR");
    end
    $finish;
  end

endmodule
